// ===== rtl/skvt_pkg.sv =====
// ----------------------------------------------------------------------------
// skvt_pkg
// Types, codes and helper functions shared by the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_GET    = 2'd1,
      OP_RANK   = 2'd2,
      OP_SELECT = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_MISS  = 2'd1,
      STS_FULL  = 2'd2,
      STS_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_WRITE,
      ACT_INSERT
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_COMMIT
   } state_type;

   // Broadcast from the sequencer to every cell of the row
   typedef struct packed {
      opcode_type opcode;
      action_type action;
   } cell_ctl_type;

   localparam int TREE_FANIN_LOG = 4;
   localparam int TREE_FANIN     = 1 << TREE_FANIN_LOG;

   // Registered levels needed to gather one record out of the given leaves
   function automatic int tree_levels(input int leaves);
      int lv;
      int span;
      lv   = 1;
      span = TREE_FANIN;
      while (span < leaves) begin
         lv   = lv + 1;
         span = span * TREE_FANIN;
      end
      return lv;
   endfunction

endpackage

// ===== rtl/skvt_if.sv =====
// ----------------------------------------------------------------------------
// skvt_req_if / skvt_rsp_if
// Valid/ready channels carrying table operations and their results.
// ----------------------------------------------------------------------------
interface skvt_req_if #(
   parameter int KW = 32,
   parameter int VW = 32
);
   import skvt_pkg::*;

   logic          valid;
   logic          ready;
   opcode_type    opcode;
   logic [KW-1:0] key;
   logic [VW-1:0] value;
   logic [7:0]    index;

   modport source (output valid, opcode, key, value, index, input ready);
   modport sink   (input valid, opcode, key, value, index, output ready);
endinterface

interface skvt_rsp_if #(
   parameter int KW = 32,
   parameter int VW = 32,
   parameter int CW = 9
);
   import skvt_pkg::*;

   logic          valid;
   logic          ready;
   status_type    status;
   logic [VW-1:0] value_out;
   logic [CW-1:0] rank_out;
   logic [KW-1:0] key_out;
   logic [CW-1:0] count;

   modport source (output valid, status, value_out, rank_out, key_out, count, input ready);
   modport sink   (input valid, status, value_out, rank_out, key_out, count, output ready);
endinterface

// ===== rtl/skvt_cell.sv =====
// ----------------------------------------------------------------------------
// skvt_cell
// One slot of the sorted row: holds a key/value pair, compares it against the
// operation key and shifts up from its lower neighbour on insert.
// ----------------------------------------------------------------------------
module skvt_cell #(
   parameter int KW  = 32,
   parameter int VW  = 32,
   parameter int CW  = 9,
   parameter int IW  = 8,
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  skvt_pkg::cell_ctl_type ctl,
   input  logic [KW-1:0]         op_key,
   input  logic [VW-1:0]         op_value,
   input  logic [7:0]            op_index,
   input  logic [CW-1:0]         count,
   input  logic                  left_less,
   input  logic [KW-1:0]         left_key,
   input  logic [VW-1:0]         left_value,
   output logic                  less,
   output logic [KW-1:0]         key_o,
   output logic [VW-1:0]         value_o,
   output logic [IW+KW+VW+1:0]   rec
);
   import skvt_pkg::*;

   localparam int XW = (IW > 8) ? IW : 8;

   logic [KW-1:0] key_ff;
   logic [VW-1:0] value_ff;
   logic          occupied;
   logic          first;
   logic          pick;

   assign occupied = CW'(IDX) < count;
   assign less     = occupied && (key_ff < op_key);
   // first slot whose key is not below the operation key: the rank position
   assign first    = !less && left_less;
   assign pick     = (ctl.opcode == OP_SELECT) ? (XW'(op_index) == XW'(IDX)) : first;
   assign rec      = pick ? {1'b1, occupied, IW'(IDX), key_ff, value_ff} : '0;
   assign key_o    = key_ff;
   assign value_o  = value_ff;

   always_ff @(posedge clock) begin
      case (ctl.action)
         ACT_WRITE: begin
            if (first) begin
               value_ff <= op_value;
            end
         end
         ACT_INSERT: begin
            if (first) begin
               key_ff   <= op_key;
               value_ff <= op_value;
            end else if (!less) begin
               key_ff   <= left_key;
               value_ff <= left_value;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/skvt_or_tree.sv =====
// ----------------------------------------------------------------------------
// skvt_or_tree
// Registered OR tree that gathers the single record a row of cells offers.
// ----------------------------------------------------------------------------
module skvt_or_tree #(
   parameter int N = 256,
   parameter int W = 8
) (
   input  logic                clock,
   input  logic [N-1:0][W-1:0] leaf,
   output logic [W-1:0]        root
);
   import skvt_pkg::*;

   localparam int LEVELS = tree_levels(N);
   localparam int PAD    = 1 << (TREE_FANIN_LOG * LEVELS);

   function automatic int lvl_size(input int l);
      return PAD >> (TREE_FANIN_LOG * (l + 1));
   endfunction

   function automatic int lvl_off(input int l);
      int o;
      o = 0;
      for (int j = 0; j < l; j++) begin
         o = o + lvl_size(j);
      end
      return o;
   endfunction

   localparam int TOTAL = lvl_off(LEVELS);

   logic [PAD-1:0][W-1:0] leaf_pad;
   logic [W-1:0]          node_ff [TOTAL];

   for (genvar i = 0; i < PAD; i++) begin : g_pad
      if (i < N) begin : g_real
         assign leaf_pad[i] = leaf[i];
      end else begin : g_zero
         assign leaf_pad[i] = '0;
      end
   end

   for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
      for (genvar n = 0; n < lvl_size(l); n++) begin : g_node
         logic [TREE_FANIN-1:0][W-1:0] kids;
         logic [W-1:0]                 node_in;

         for (genvar c = 0; c < TREE_FANIN; c++) begin : g_kid
            if (l == 0) begin : g_leaf
               assign kids[c] = leaf_pad[n*TREE_FANIN + c];
            end else begin : g_inner
               assign kids[c] = node_ff[lvl_off(l-1) + n*TREE_FANIN + c];
            end
         end

         always_comb begin
            node_in = '0;
            for (int c = 0; c < TREE_FANIN; c++) begin
               node_in = node_in | kids[c];
            end
         end

         always_ff @(posedge clock) begin
            node_ff[lvl_off(l) + n] <= node_in;
         end
      end
   end

   assign root = node_ff[TOTAL-1];

endmodule

// ===== rtl/sorted_key_value_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_key_value_table_unit
// Fixed-capacity key/value table kept sorted by ascending key.
// ----------------------------------------------------------------------------
// Operations arrive on req_ch (put, get, rank, select) and each one gives
// exactly one item on rsp_ch, carrying the entry count after the operation.
// The pairs live in a row of CAPACITY cells. Every cell compares its key
// with the operation key at once; the cell at the rank position (or at the
// selected index) offers its pair into a registered 16-way OR tree of
// L = ceil(log16(CAPACITY)) levels. An insert shifts all cells at and above
// the rank up by one together, at commit.
// The operation is held in registers while its record passes the L tree
// levels, and the result is registered at commit. One operation is in
// flight at a time, so a new request is taken only after the previous one
// has committed.
// Reset clears the entry count and the handshake state; the table contents
// need no clearing. A stalled response holds in the output register; the
// next request is still taken and waits at commit until the output is free.
// ----------------------------------------------------------------------------
module sorted_key_value_table_unit #(
   parameter int CAPACITY    = 256,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   skvt_req_if.sink   req_ch,
   skvt_rsp_if.source rsp_ch
);
   import skvt_pkg::*;

   localparam int KW     = KEY_WIDTH;
   localparam int VW     = VALUE_WIDTH;
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int IW     = $clog2(CAPACITY);
   localparam int RW     = IW + KW + VW + 2;
   localparam int LEVELS = tree_levels(CAPACITY);
   localparam int WW     = $clog2(LEVELS + 1);

   localparam int R_VAL = 0;
   localparam int R_KEY = VW;
   localparam int R_IDX = VW + KW;
   localparam int R_OCC = VW + KW + IW;
   localparam int R_HIT = VW + KW + IW + 1;

   state_type     state_ff, state_in;
   logic [WW-1:0] wait_ff, wait_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff;

   opcode_type    opcode_ff;
   logic [KW-1:0] key_ff;
   logic [VW-1:0] value_ff;
   logic [7:0]    index_ff;

   status_type    rsp_status_ff, rsp_status_in;
   logic [VW-1:0] rsp_value_ff, rsp_value_in;
   logic [CW-1:0] rsp_rank_ff, rsp_rank_in;
   logic [KW-1:0] rsp_key_ff, rsp_key_in;

   logic          req_take;
   logic          commit_fire;
   action_type    act;
   cell_ctl_type  ctl;

   logic [CAPACITY-1:0]         less_w;
   logic [KW-1:0]               cell_key_w   [CAPACITY];
   logic [VW-1:0]               cell_value_w [CAPACITY];
   logic [CAPACITY-1:0][RW-1:0] leaf_w;
   logic [RW-1:0]               root;

   logic          root_hit;
   logic          root_occ;
   logic [IW-1:0] root_idx;
   logic [KW-1:0] root_key;
   logic [VW-1:0] root_value;
   logic [CW-1:0] rank_w;
   logic          found;

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (wait_ff == WW'(1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_take    = 1'b0;
      commit_fire = 1'b0;
      wait_in     = wait_ff;
      case (state_ff)
         ST_IDLE: begin
            req_take = req_ch.valid;
            wait_in  = WW'(LEVELS);
         end
         ST_LOOKUP: begin
            wait_in = wait_ff - WW'(1);
         end
         ST_COMMIT: begin
            commit_fire = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
         end
      endcase
   end

   assign req_ch.ready = (state_ff == ST_IDLE) && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         count_ff <= count_in;
         if (commit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the operation for the whole lookup
   always_ff @(posedge clock) begin
      if (req_take) begin
         opcode_ff <= req_ch.opcode;
         key_ff    <= req_ch.key;
         value_ff  <= req_ch.value;
         index_ff  <= req_ch.index;
      end
      if (commit_fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_rank_ff   <= rsp_rank_in;
         rsp_key_ff    <= rsp_key_in;
      end
   end

   // ---- cell row ----
   assign ctl.opcode = opcode_ff;
   assign ctl.action = commit_fire ? act : ACT_NONE;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         skvt_cell #(.KW(KW), .VW(VW), .CW(CW), .IW(IW), .IDX(i)) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .op_key     (key_ff),
            .op_value   (value_ff),
            .op_index   (index_ff),
            .count      (count_ff),
            .left_less  (1'b1),
            .left_key   ('0),
            .left_value ('0),
            .less       (less_w[i]),
            .key_o      (cell_key_w[i]),
            .value_o    (cell_value_w[i]),
            .rec        (leaf_w[i])
         );
      end else begin : g_body
         skvt_cell #(.KW(KW), .VW(VW), .CW(CW), .IW(IW), .IDX(i)) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .op_key     (key_ff),
            .op_value   (value_ff),
            .op_index   (index_ff),
            .count      (count_ff),
            .left_less  (less_w[i-1]),
            .left_key   (cell_key_w[i-1]),
            .left_value (cell_value_w[i-1]),
            .less       (less_w[i]),
            .key_o      (cell_key_w[i]),
            .value_o    (cell_value_w[i]),
            .rec        (leaf_w[i])
         );
      end
   end

   skvt_or_tree #(.N(CAPACITY), .W(RW)) u_tree (
      .clock (clock),
      .leaf  (leaf_w),
      .root  (root)
   );

   // ---- result decode ----
   assign root_hit   = root[R_HIT];
   assign root_occ   = root[R_OCC];
   assign root_idx   = root[R_IDX +: IW];
   assign root_key   = root[R_KEY +: KW];
   assign root_value = root[R_VAL +: VW];

   // no rank cell only when every slot is full and below the key
   assign rank_w = root_hit ? CW'(root_idx) : CW'(CAPACITY);
   assign found  = root_hit && root_occ && (root_key == key_ff);

   always_comb begin
      act           = ACT_NONE;
      count_in      = count_ff;
      rsp_status_in = STS_OK;
      rsp_value_in  = '0;
      rsp_rank_in   = '0;
      rsp_key_in    = '0;
      case (opcode_ff)
         OP_PUT: begin
            rsp_rank_in = rank_w;
            if (found) begin
               act = ACT_WRITE;
            end else if (count_ff == CW'(CAPACITY)) begin
               rsp_status_in = STS_FULL;
            end else begin
               act = ACT_INSERT;
               if (commit_fire) begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         OP_GET: begin
            rsp_rank_in = rank_w;
            if (found) begin
               rsp_value_in = root_value;
            end else begin
               rsp_status_in = STS_MISS;
            end
         end
         OP_RANK: begin
            rsp_rank_in = rank_w;
         end
         OP_SELECT: begin
            if (root_hit && root_occ) begin
               rsp_value_in = root_value;
               rsp_key_in   = root_key;
               rsp_rank_in  = CW'(root_idx);
            end else begin
               rsp_status_in = STS_RANGE;
            end
         end
         default: begin
            rsp_status_in = STS_OK;
         end
      endcase
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.value_out = rsp_value_ff;
   assign rsp_ch.rank_out  = rsp_rank_ff;
   assign rsp_ch.key_out   = rsp_key_ff;
   assign rsp_ch.count     = count_ff;

   // ---- assertions ----
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (commit_fire && act == ACT_INSERT) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not advance the entry count");

   a_count_hold : assert property (@(posedge clock) disable iff (reset)
      !(commit_fire && act == ACT_INSERT) |=> $stable(count_ff))
      else $error("entry count moved without an insert");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(commit_fire))
      else $error("response raised without a commit");

   a_rank_cell : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && opcode_ff != OP_SELECT && count_ff != CW'(CAPACITY))
      |-> root_hit)
      else $error("no rank cell found in a table with free room");

endmodule

// ===== verif/tb_sorted_key_value_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_key_value_table_unit
// Self-checking bench for the sorted key/value table.
// ----------------------------------------------------------------------------
// A short table of operations first walks the empty table and the extreme
// keys and values. A random stream follows. It fills the table to capacity,
// which brings out the table-full status, and then keeps working on the full
// table. A shadow copy of the table in the bench works out each result as
// its operation is taken. Results are compared in order, field by field.
// Both channels pause in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_sorted_key_value_table_unit;
   import skvt_pkg::*;

   localparam int          CAPACITY      = 256;
   localparam int          N_RANDOM      = 1030;
   localparam int          CALM_TAIL     = 100;
   localparam int          DRAIN_CYCLES  = 12;
   localparam int unsigned STALL_LIMIT   = 2000;

   typedef struct packed {
      opcode_type  op;
      logic [31:0] key;
      logic [31:0] value;
      logic [7:0]  index;
   } table_op_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] value_out;
      logic [8:0]  rank_out;
      logic [31:0] key_out;
      logic [8:0]  count;
   } table_rsp_type;

   typedef struct packed {
      table_op_type  cmd;
      logic          typed;
      table_rsp_type want;
   } directed_row_type;

   logic clock;
   logic reset;
   bit   calm;

   skvt_req_if #(.KW(32), .VW(32))          req_ch ();
   skvt_rsp_if #(.KW(32), .VW(32), .CW(9))  rsp_ch ();

   sorted_key_value_table_unit #(
      .CAPACITY    (CAPACITY),
      .KEY_WIDTH   (32),
      .VALUE_WIDTH (32)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the table, updated as each operation is taken
   logic [31:0] shadow_keys   [CAPACITY];
   logic [31:0] shadow_values [CAPACITY];
   int unsigned shadow_count;

   table_rsp_type pending_results [$];
   int unsigned   mismatches;
   int unsigned   results_seen;
   int unsigned   quiet_cycles;

   // typed rows carry a result that can be read off directly
   directed_row_type directed [21] = '{
      '{'{OP_GET,    32'h0000_0000, 32'h0000_0000, 8'd0},   1'b1,
        '{STS_MISS,  32'h0000_0000, 9'd0, 32'h0000_0000, 9'd0}},
      '{'{OP_RANK,   32'hFFFF_FFFF, 32'h0000_0000, 8'd0},   1'b1,
        '{STS_OK,    32'h0000_0000, 9'd0, 32'h0000_0000, 9'd0}},
      '{'{OP_SELECT, 32'h0000_0000, 32'h0000_0000, 8'd0},   1'b1,
        '{STS_RANGE, 32'h0000_0000, 9'd0, 32'h0000_0000, 9'd0}},
      '{'{OP_SELECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255}, 1'b1,
        '{STS_RANGE, 32'h0000_0000, 9'd0, 32'h0000_0000, 9'd0}},
      '{'{OP_PUT,    32'h0000_0000, 32'hFFFF_FFFF, 8'd0},   1'b1,
        '{STS_OK,    32'h0000_0000, 9'd0, 32'h0000_0000, 9'd1}},
      '{'{OP_PUT,    32'hFFFF_FFFF, 32'h0000_0000, 8'd0},   1'b1,
        '{STS_OK,    32'h0000_0000, 9'd1, 32'h0000_0000, 9'd2}},
      '{'{OP_GET,    32'h0000_0000, 32'h0000_0000, 8'd0},   1'b1,
        '{STS_OK,    32'hFFFF_FFFF, 9'd0, 32'h0000_0000, 9'd2}},
      '{'{OP_GET,    32'hFFFF_FFFF, 32'h0000_0000, 8'd0},   1'b1,
        '{STS_OK,    32'h0000_0000, 9'd1, 32'h0000_0000, 9'd2}},
      '{'{OP_PUT,    32'h8000_0000, 32'h1234_5678, 8'd0},   1'b1,
        '{STS_OK,    32'h0000_0000, 9'd1, 32'h0000_0000, 9'd3}},
      '{'{OP_PUT,    32'h0000_0000, 32'h5A5A_5A5A, 8'd0},   1'b1,
        '{STS_OK,    32'h0000_0000, 9'd0, 32'h0000_0000, 9'd3}},
      '{'{OP_GET,    32'h0000_0000, 32'h0000_0000, 8'd0},   1'b0, '0},
      '{'{OP_SELECT, 32'h0000_0000, 32'h0000_0000, 8'd2},   1'b0, '0},
      '{'{OP_SELECT, 32'h0000_0000, 32'h0000_0000, 8'd0},   1'b0, '0},
      '{'{OP_SELECT, 32'h0000_0000, 32'h0000_0000, 8'd3},   1'b1,
        '{STS_RANGE, 32'h0000_0000, 9'd0, 32'h0000_0000, 9'd3}},
      '{'{OP_RANK,   32'h8000_0000, 32'h0000_0000, 8'd0},   1'b0, '0},
      '{'{OP_RANK,   32'h8000_0001, 32'h0000_0000, 8'd0},   1'b0, '0},
      '{'{OP_GET,    32'h7FFF_FFFF, 32'h0000_0000, 8'd0},   1'b0, '0},
      '{'{OP_PUT,    32'h7FFF_FFFF, 32'hA5A5_A5A5, 8'd0},   1'b0, '0},
      '{'{OP_PUT,    32'h0000_0001, 32'h0000_0001, 8'd0},   1'b0, '0},
      '{'{OP_RANK,   32'hFFFF_FFFF, 32'h0000_0000, 8'd0},   1'b0, '0},
      '{'{OP_SELECT, 32'h0000_0000, 32'h0000_0000, 8'd4},   1'b0, '0}
   };

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Apply one operation to the shadow table and give its result
   function automatic table_rsp_type apply_table_op(table_op_type cmd);
      table_rsp_type res;
      int unsigned   pos;
      bit            hit;
      res  = '0;
      res.status = STS_OK;
      pos  = 0;
      while (pos < shadow_count && shadow_keys[pos] < cmd.key) pos++;
      hit  = (pos < shadow_count) && (shadow_keys[pos] == cmd.key);
      case (cmd.op)
         OP_PUT: begin
            res.rank_out = 9'(pos);
            if (hit) begin
               shadow_values[pos] = cmd.value;
            end else if (shadow_count >= CAPACITY) begin
               res.status = STS_FULL;
            end else begin
               // shift from the top down so nothing is overwritten
               for (int j = shadow_count; j > pos; j--) begin
                  shadow_keys[j]   = shadow_keys[j-1];
                  shadow_values[j] = shadow_values[j-1];
               end
               shadow_keys[pos]   = cmd.key;
               shadow_values[pos] = cmd.value;
               shadow_count++;
            end
         end
         OP_GET: begin
            res.rank_out = 9'(pos);
            if (hit) res.value_out = shadow_values[pos];
            else     res.status    = STS_MISS;
         end
         OP_RANK: begin
            res.rank_out = 9'(pos);
         end
         default: begin
            if (cmd.index < shadow_count) begin
               res.key_out   = shadow_keys[cmd.index];
               res.value_out = shadow_values[cmd.index];
               res.rank_out  = 9'(cmd.index);
            end else begin
               res.status = STS_RANGE;
            end
         end
      endcase
      res.count = 9'(shadow_count);
      return res;
   endfunction

   // Draw an operation; keys lean on stored keys and their neighbours
   function automatic table_op_type random_table_op();
      table_op_type cmd;
      int unsigned  roll;
      int unsigned  pick;
      int unsigned  near;
      bit           filling;
      filling = (shadow_count < CAPACITY);
      roll    = $urandom_range(0, 99);
      if (roll < (filling ? 65 : 30))      cmd.op = OP_PUT;
      else if (roll < (filling ? 78 : 55)) cmd.op = OP_GET;
      else if (roll < (filling ? 88 : 75)) cmd.op = OP_RANK;
      else                                 cmd.op = OP_SELECT;
      cmd.value = $urandom();
      near = (filling && cmd.op == OP_PUT) ? 10 : 40;
      pick = (shadow_count == 0) ? 0 : $urandom_range(0, shadow_count - 1);
      roll = $urandom_range(0, 99);
      if (shadow_count != 0 && roll < near) begin
         cmd.key = shadow_keys[pick];
      end else if (shadow_count != 0 && roll < near + 15) begin
         cmd.key = $urandom_range(0, 1) ? shadow_keys[pick] + 32'd1
                                        : shadow_keys[pick] - 32'd1;
      end else if (roll < near + 22) begin
         case ($urandom_range(0, 3))
            0:       cmd.key = 32'h0000_0000;
            1:       cmd.key = 32'hFFFF_FFFF;
            2:       cmd.key = 32'h8000_0000;
            default: cmd.key = 32'h7FFF_FFFF;
         endcase
      end else begin
         cmd.key = $urandom();
      end
      roll = $urandom_range(0, 9);
      if (roll == 0)
         cmd.index = (shadow_count > 255) ? 8'hFF : 8'(shadow_count);
      else if (roll < 7 && shadow_count != 0)
         cmd.index = 8'($urandom_range(0, shadow_count - 1));
      else
         cmd.index = 8'($urandom_range(0, 255));
      return cmd;
   endfunction

   task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d, %s: got %h, expected %h",
               results_seen, field, got, want);
      mismatches++;
   endtask

   // Offer one item, hold it until taken, then record its result
   task automatic drive_table_op(table_op_type cmd, logic typed, table_rsp_type want,
                                 int unsigned idle_pct);
      table_rsp_type predicted;
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= cmd.op;
      req_ch.key    <= cmd.key;
      req_ch.value  <= cmd.value;
      req_ch.index  <= cmd.index;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = apply_table_op(cmd);
      pending_results.push_back(typed ? want : predicted);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Result side: ready drops in random bursts
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (!calm && $urandom_range(0, 1)) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      table_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("unexpected item, status", 32'(rsp_ch.status), '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.status !== want.status)
               flag_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
            if (rsp_ch.value_out !== want.value_out)
               flag_mismatch("value_out", rsp_ch.value_out, want.value_out);
            if (rsp_ch.rank_out !== want.rank_out)
               flag_mismatch("rank_out", 32'(rsp_ch.rank_out), 32'(want.rank_out));
            if (rsp_ch.key_out !== want.key_out)
               flag_mismatch("key_out", rsp_ch.key_out, want.key_out);
            if (rsp_ch.count !== want.count)
               flag_mismatch("count", 32'(rsp_ch.count), 32'(want.count));
         end
         results_seen++;
      end
   end

   // Watchdog: give up when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", quiet_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned idle_pct;
      shadow_count  = 0;
      calm          = 1'b0;
      idle_pct      = 30;
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.opcode <= OP_PUT;
      req_ch.key    <= '0;
      req_ch.value  <= '0;
      req_ch.index  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         drive_table_op(directed[i].cmd, directed[i].typed, directed[i].want, 30);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 64 == 0) idle_pct = $urandom_range(0, 1) ? 35 : 0;
         if (n >= N_RANDOM - CALM_TAIL) calm = 1'b1;
         drive_table_op(random_table_op(), 1'b0, '0, calm ? 0 : idle_pct);
      end
      req_ch.valid <= 1'b0;

      // drain, then keep watching for anything stray
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
